>>> rtl/gcno_pkg.sv
// shared types, constants and helpers for the grid cell neighbourhood occupancy block
// no dependencies
package gcno_pkg;

  localparam int GRID_DIM_MAX = 32;
  localparam int COUNT_WIDTH  = 16;
  localparam int CELLS        = GRID_DIM_MAX * GRID_DIM_MAX;
  localparam int CELL_BITS    = $clog2(GRID_DIM_MAX);
  localparam int ADDR_W       = $clog2(CELLS);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  localparam int POS_W = 24;
  localparam int CS_W  = 23;
  localparam int DIM_W = 6;
  localparam int IDX_W = 5;
  localparam int Q_DEPTH = 2;

  localparam logic [1:0] OP_PLACE  = 2'd0;
  localparam logic [1:0] OP_MOVE   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic [2:0] CFG_MIN_X = 3'd0;
  localparam logic [2:0] CFG_MIN_Z = 3'd1;
  localparam logic [2:0] CFG_MAX_X = 3'd2;
  localparam logic [2:0] CFG_MAX_Z = 3'd3;
  localparam logic [2:0] CFG_CELL  = 3'd4;
  localparam logic [2:0] CFG_COLS  = 3'd5;
  localparam logic [2:0] CFG_ROWS  = 3'd6;

  typedef struct packed {
    logic signed [POS_W-1:0] min_x;
    logic signed [POS_W-1:0] min_z;
    logic signed [POS_W-1:0] max_x;
    logic signed [POS_W-1:0] max_z;
    logic [CS_W-1:0]         cell_size;
    logic [DIM_W-1:0]        grid_cols;
    logic [DIM_W-1:0]        grid_rows;
  } cfg_t;

  typedef struct packed {
    logic             inc;
    logic             dec;
    logic             changed;
    logic [IDX_W-1:0] nx;
    logic [IDX_W-1:0] nz;
    logic [IDX_W-1:0] ox;
    logic [IDX_W-1:0] oz;
  } job_t;

  typedef enum logic [1:0] {F_IDLE, F_OFF, F_DIV, F_PUSH} front_state_t;
  typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_SCAN, B_WR, B_DONE} back_state_t;

  function automatic logic [DIM_W-1:0] dim_used(input logic [DIM_W-1:0] d);
    if (d == '0) begin
      return DIM_W'(1);
    end else if (d > DIM_W'(GRID_DIM_MAX)) begin
      return DIM_W'(GRID_DIM_MAX);
    end
    return d;
  endfunction

endpackage

>>> rtl/gcno_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module gcno_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/gcno_front.sv
// front end: accepts input beats, finds the cell index per axis with a short shift-subtract
// divider and builds a counter update job; uses gcno_pkg
module gcno_front import gcno_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        clearing,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // pos_x, pos_z, old_cell_x, old_cell_z, zero fill
  input  logic [1:0]  s_tuser,   // op
  output job_t        job,
  output logic        push,
  input  logic        full
);

  front_state_t state, state_next;

  logic [1:0]              op_r;
  logic signed [POS_W-1:0] px, pz;
  logic [IDX_W-1:0]        ox, oz;
  logic [POS_W-1:0]        rem_x, rem_z;
  logic [5:0]              q_x, q_z;
  logic [2:0]              step;

  logic [CS_W-1:0]  cs_eff;
  logic [28:0]      trial;
  logic             ge_x, ge_z;
  logic [DIM_W-1:0] cols, rows;
  logic [IDX_W-1:0] nx, nz;
  logic             accept, moved, is_move;

  function automatic logic [POS_W-1:0] axis_offset(input logic signed [POS_W-1:0] p,
                                                   input logic signed [POS_W-1:0] lo,
                                                   input logic signed [POS_W-1:0] hi);
    logic signed [POS_W-1:0] c;
    logic signed [POS_W:0]   d;
    c = (p > hi) ? hi : p;
    c = (c < lo) ? lo : c;
    d = (POS_W+1)'(c) - (POS_W+1)'(lo);
    return d[POS_W] ? '0 : d[POS_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] clamp_idx(input logic [5:0] q,
                                                 input logic [DIM_W-1:0] n);
    logic [IDX_W-1:0] lim, qc;
    lim = IDX_W'(n - DIM_W'(1));
    qc  = q[5] ? '1 : q[IDX_W-1:0];
    return (qc > lim) ? lim : qc;
  endfunction

  assign accept = s_tvalid && s_tready;
  assign cs_eff = (cfg.cell_size == '0) ? CS_W'(1) : cfg.cell_size;
  assign trial  = 29'(cs_eff) << step;
  assign ge_x   = 29'(rem_x) >= trial;
  assign ge_z   = 29'(rem_z) >= trial;
  assign cols   = dim_used(cfg.grid_cols);
  assign rows   = dim_used(cfg.grid_rows);
  assign nx     = clamp_idx(q_x, cols);
  assign nz     = clamp_idx(q_z, rows);
  assign is_move = op_r == OP_MOVE;
  assign moved   = (nx != ox) || (nz != oz);

  always_comb begin
    job.inc     = (op_r == OP_PLACE) || (is_move && moved);
    job.dec     = (is_move && moved) || (op_r == OP_REMOVE);
    job.changed = job.inc;
    job.nx      = nx;
    job.nz      = nz;
    job.ox      = ox;
    job.oz      = oz;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (accept) begin
          state_next = (s_tuser == OP_PLACE || s_tuser == OP_MOVE) ? F_OFF : F_PUSH;
        end
      end
      F_OFF: state_next = F_DIV;
      F_DIV: begin
        if (step == 3'd0) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == F_IDLE) && !clearing;
    push     = (state == F_PUSH) && !full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= s_tuser;
      px   <= s_tdata[23:0];
      pz   <= s_tdata[47:24];
      ox   <= s_tdata[52:48];
      oz   <= s_tdata[57:53];
      q_x  <= '0;
      q_z  <= '0;
    end
    if (state == F_OFF) begin
      rem_x <= axis_offset(px, cfg.min_x, cfg.max_x);
      rem_z <= axis_offset(pz, cfg.min_z, cfg.max_z);
      q_x   <= '0;
      q_z   <= '0;
      step  <= 3'd5;
    end
    if (state == F_DIV) begin
      if (ge_x) begin
        rem_x     <= rem_x - trial[POS_W-1:0];
        q_x[step] <= 1'b1;
      end
      if (ge_z) begin
        rem_z     <= rem_z - trial[POS_W-1:0];
        q_z[step] <= 1'b1;
      end
      step <= step - 3'd1;
    end
  end

endmodule

>>> rtl/gcno_queue.sv
// two entry job queue between front and back end
// uses gcno_pkg
module gcno_queue import gcno_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output job_t dout,
  output logic empty
);

  job_t       slots [Q_DEPTH];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full  = count == 2'(Q_DEPTH);
  assign empty = count == 2'd0;
  assign dout  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= din;
    end
  end

endmodule

>>> rtl/gcno_back.sv
// back end: clears the counters after reset, then runs the 3x3 read-modify-write passes
// of each job and holds the result beat; uses gcno_pkg and gcno_ram
module gcno_back import gcno_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  job_t        job_in,
  input  logic        empty,
  output logic        pop,
  output logic        clearing,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // cell_x, cell_z, cell_changed, zero fill
);

  back_state_t state, state_next;

  job_t              job;
  logic              phase;
  logic [1:0]        dxi, dzi;
  logic [ADDR_W-1:0] clr_addr, rmw_addr;

  logic [IDX_W-1:0]       cx, cz;
  logic [IDX_W+1:0]       xs, zs;
  logic [DIM_W-1:0]       cols, rows;
  logic                   nb_ok, last_nb, more, out_free, ram_we;
  logic [ADDR_W-1:0]      ram_waddr, nb_addr;
  logic [COUNT_WIDTH-1:0] ram_wdata, rdata, upd;

  assign cols     = dim_used(cfg.grid_cols);
  assign rows     = dim_used(cfg.grid_rows);
  assign cx       = phase ? job.ox : job.nx;
  assign cz       = phase ? job.oz : job.nz;
  assign xs       = (IDX_W+2)'(cx) + (IDX_W+2)'(dxi) - (IDX_W+2)'(1);
  assign zs       = (IDX_W+2)'(cz) + (IDX_W+2)'(dzi) - (IDX_W+2)'(1);
  assign nb_ok    = !xs[IDX_W+1] && !zs[IDX_W+1] &&
                    (xs < (IDX_W+2)'(cols)) && (zs < (IDX_W+2)'(rows));
  assign nb_addr  = {xs[CELL_BITS-1:0], zs[CELL_BITS-1:0]};
  assign last_nb  = (dxi == 2'd2) && (dzi == 2'd2);
  assign more     = !phase && job.dec;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    if (phase) begin
      upd = (rdata == '0) ? rdata : rdata - COUNT_WIDTH'(1);
    end else begin
      upd = (rdata == COUNT_MAX) ? rdata : rdata + COUNT_WIDTH'(1);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_CLEAR: begin
        if (clr_addr == ADDR_W'(CELLS - 1)) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!empty) begin
          state_next = (job_in.inc || job_in.dec) ? B_SCAN : B_DONE;
        end
      end
      B_SCAN: begin
        if (nb_ok) begin
          state_next = B_WR;
        end else if (last_nb && !more) begin
          state_next = B_DONE;
        end
      end
      B_WR: state_next = (last_nb && !more) ? B_DONE : B_SCAN;
      B_DONE: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    clearing  = state == B_CLEAR;
    pop       = (state == B_IDLE) && !empty;
    ram_we    = (state == B_CLEAR) || (state == B_WR);
    ram_waddr = (state == B_CLEAR) ? clr_addr : rmw_addr;
    ram_wdata = (state == B_CLEAR) ? '0 : upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (state == B_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job   <= job_in;
      phase <= !job_in.inc;
      dxi   <= 2'd0;
      dzi   <= 2'd0;
    end
    if (state == B_SCAN) begin
      rmw_addr <= nb_addr;
    end
    if ((state == B_SCAN && !nb_ok) || state == B_WR) begin
      if (dzi == 2'd2) begin
        dzi <= 2'd0;
        if (dxi == 2'd2) begin
          dxi   <= 2'd0;
          phase <= 1'b1;
        end else begin
          dxi <= dxi + 2'd1;
        end
      end else begin
        dzi <= dzi + 2'd1;
      end
    end
    if (state == B_DONE && out_free) begin
      m_tdata <= job.changed ? {5'd0, 1'b1, job.nz, job.nx} : {5'd0, 1'b0, job.oz, job.ox};
    end
  end

  gcno_ram #(
    .WIDTH(COUNT_WIDTH),
    .DEPTH(CELLS)
  ) u_counts (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(nb_addr),
    .rdata(rdata)
  );

  a_we_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == B_WR || state == B_CLEAR))
    else $error("counter write outside clear or update");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    (state == B_CLEAR) |-> !pop)
    else $error("job taken during clearing pass");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == B_DONE))
    else $error("result raised outside done state");

  a_wr_after_scan: assert property (@(posedge clk) disable iff (rst)
    (state == B_WR) |-> $past(state == B_SCAN))
    else $error("counter update without read");

endmodule

>>> rtl/grid_cell_neighbourhood_occupancy.sv
// top level of the grid cell neighbourhood occupancy block: config registers, front end,
// job queue and back end; uses gcno_pkg, gcno_front, gcno_queue, gcno_back
//
// Keeps a 32x32 grid of saturating 16-bit occupancy counters. After reset the block clears
// the counter memory, one entry per cycle, and holds s_tready low; config writes are taken
// as ever. An item (op in s_tuser) is taken one at a time by the front end: place and move
// pass through an offset clamp, then a 6-step shift-subtract divider per axis, while remove
// and nop go straight to the push. The back end then walks the 3x3 neighbourhood through
// the single counter memory: a scan step per neighbour, plus a write step for each on-grid
// one; a move that changes cell walks both the new and the old neighbourhood, and the back
// end also takes the job and posts the result. A two-entry queue lets the front end work on
// the next item while the back end is still busy, so the steady rate is set by the back end.
module grid_cell_neighbourhood_occupancy import gcno_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // pos_x, pos_z, old_cell_x, old_cell_z, zero fill
  input  logic [1:0]  s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // cell_x, cell_z, cell_changed, zero fill
);

  cfg_t cfg;
  job_t fj, qj;
  logic push, full, pop, empty, clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_x     <= '0;
      cfg.min_z     <= '0;
      cfg.max_x     <= '0;
      cfg.max_z     <= '0;
      cfg.cell_size <= CS_W'(256);
      cfg.grid_cols <= DIM_W'(32);
      cfg.grid_rows <= DIM_W'(32);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MIN_X: cfg.min_x     <= cfg_data;
        CFG_MIN_Z: cfg.min_z     <= cfg_data;
        CFG_MAX_X: cfg.max_x     <= cfg_data;
        CFG_MAX_Z: cfg.max_z     <= cfg_data;
        CFG_CELL:  cfg.cell_size <= cfg_data[CS_W-1:0];
        CFG_COLS:  cfg.grid_cols <= cfg_data[DIM_W-1:0];
        CFG_ROWS:  cfg.grid_rows <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  gcno_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .clearing(clearing),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .job     (fj),
    .push    (push),
    .full    (full)
  );

  gcno_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (fj),
    .full (full),
    .pop  (pop),
    .dout (qj),
    .empty(empty)
  );

  gcno_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .job_in  (qj),
    .empty   (empty),
    .pop     (pop),
    .clearing(clearing),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

endmodule

>>> test/tb_grid_cell_neighbourhood_occupancy.sv
// testbench for grid_cell_neighbourhood_occupancy: directed and random place/move/remove beats
// against an in-bench grid predictor, with random idling on both stream sides
// depends on gcno_pkg and the rtl of the block
module tb_grid_cell_neighbourhood_occupancy;
  import gcno_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [IDX_W-1:0] cx;
    logic [IDX_W-1:0] cz;
    logic             chg;
  } cell_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [23:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  logic signed [23:0] g_min_x, g_min_z, g_max_x, g_max_z;
  logic [22:0]        g_cell;
  logic [5:0]         g_cols, g_rows;
  int unsigned        occ [CELLS];

  cell_result_t pending_cells [$];
  logic [9:0]   movers [$];
  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int moves_changed = 0;
  int cfg_phases = 0;
  bit calm = 0;
  int hold_cycles = 0;

  grid_cell_neighbourhood_occupancy dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------- predictor ----------------
  function automatic int unsigned dim_in_use(logic [5:0] d);
    if (d == 0) return 1;
    if (d > GRID_DIM_MAX) return GRID_DIM_MAX;
    return d;
  endfunction

  function automatic logic [IDX_W-1:0] axis_index(logic signed [23:0] p, logic signed [23:0] lo,
                                                  logic signed [23:0] hi, int unsigned n);
    longint pv, off, q, cs;
    pv = p;
    cs = (g_cell == 0) ? 1 : longint'(g_cell);
    if (pv > hi) pv = hi;
    if (pv < lo) pv = lo;
    off = pv - longint'(lo);
    if (off < 0) off = 0;
    q = off / cs;
    if (q > n - 1) q = n - 1;
    return q[IDX_W-1:0];
  endfunction

  function automatic void bump_block(int cx, int cz, bit up);
    int cols, rows, x, z, a;
    cols = dim_in_use(g_cols);
    rows = dim_in_use(g_rows);
    for (int dx = -1; dx <= 1; dx++) begin
      for (int dz = -1; dz <= 1; dz++) begin
        x = cx + dx;
        z = cz + dz;
        if (x < 0 || z < 0 || x >= cols || z >= rows) continue;
        a = x * GRID_DIM_MAX + z;
        if (up) begin
          if (occ[a] < 65535) occ[a]++;
        end else begin
          if (occ[a] > 0) occ[a]--;
        end
      end
    end
  endfunction

  function automatic cell_result_t predict_cell(logic [1:0] op, logic [23:0] px,
                                                logic [23:0] pz, logic [4:0] ox,
                                                logic [4:0] oz);
    cell_result_t r;
    logic [4:0] nx, nz;
    r.cx = ox;
    r.cz = oz;
    r.chg = 1'b0;
    if (op == OP_PLACE || op == OP_MOVE) begin
      nx = axis_index(px, g_min_x, g_max_x, dim_in_use(g_cols));
      nz = axis_index(pz, g_min_z, g_max_z, dim_in_use(g_rows));
      if (op == OP_PLACE || nx != ox || nz != oz) begin
        bump_block(nx, nz, 1'b1);
        if (op == OP_MOVE) bump_block(ox, oz, 1'b0);
        r.cx = nx;
        r.cz = nz;
        r.chg = 1'b1;
      end
    end else if (op == OP_REMOVE) begin
      bump_block(ox, oz, 1'b0);
    end
    return r;
  endfunction

  // ---------------- drivers ----------------
  task automatic send_item(logic [1:0] op, logic [23:0] px, logic [23:0] pz,
                           logic [4:0] ox, logic [4:0] oz);
    cell_result_t r;
    while (!calm && $urandom_range(99) < 34) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'b0, oz, ox, pz, px};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = predict_cell(op, px, pz, ox, oz);
    pending_cells.insert(pending_cells.size(), r);
    beats_in++;
    if (r.chg && op == OP_MOVE) moves_changed++;
    if (op == OP_PLACE || (op == OP_MOVE && r.chg)) movers.insert(movers.size(), {r.cz, r.cx});
  endtask

  task automatic settle;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_MIN_X: g_min_x = val;
      CFG_MIN_Z: g_min_z = val;
      CFG_MAX_X: g_max_x = val;
      CFG_MAX_Z: g_max_z = val;
      CFG_CELL:  g_cell  = val[22:0];
      CFG_COLS:  g_cols  = val[5:0];
      CFG_ROWS:  g_rows  = val[5:0];
      default: ;
    endcase
  endtask

  task automatic set_world(logic [23:0] mnx, logic [23:0] mnz, logic [23:0] mxx,
                           logic [23:0] mxz, logic [23:0] cs, logic [5:0] cols,
                           logic [5:0] rows);
    settle();
    write_reg(CFG_MIN_X, mnx);
    write_reg(CFG_MIN_Z, mnz);
    write_reg(CFG_MAX_X, mxx);
    write_reg(CFG_MAX_Z, mxz);
    write_reg(CFG_CELL, cs);
    write_reg(CFG_COLS, {18'b0, cols});
    write_reg(CFG_ROWS, {18'b0, rows});
    cfg_we <= 1'b0;
    cfg_phases++;
  endtask

  function automatic logic [23:0] pick_pos(logic signed [23:0] lo, logic signed [23:0] hi);
    longint a, b;
    if ($urandom_range(3) == 0) return 24'($urandom);
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    a = a - 512;
    b = b + 512;
    if (a < -8388608) a = -8388608;
    if (b > 8388607) b = 8388607;
    return 24'(a + longint'($urandom) % (b - a + 1));
  endfunction

  task automatic random_item;
    int k;
    logic [9:0] m;
    logic [1:0] op;
    k = $urandom_range(99);
    if (k < 40 || movers.size() == 0) begin
      op = (k < 3) ? OP_NOP : OP_PLACE;
      send_item(op, pick_pos(g_min_x, g_max_x), pick_pos(g_min_z, g_max_z),
                5'($urandom), 5'($urandom));
    end else if (k < 90) begin
      m = movers[0];
      if (k < 75) begin
        movers.pop_front();
        send_item(OP_MOVE, pick_pos(g_min_x, g_max_x), pick_pos(g_min_z, g_max_z),
                  m[4:0], m[9:5]);
      end else begin
        movers.pop_front();
        send_item(OP_REMOVE, 24'($urandom), 24'($urandom), m[4:0], m[9:5]);
      end
    end else begin
      send_item(k < 95 ? OP_REMOVE : OP_MOVE, 24'($urandom), 24'($urandom),
                5'($urandom), 5'($urandom));
    end
  endtask

  // ---------------- receiver and checker ----------------
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (calm) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 34);
    end
  end

  always @(posedge clk) begin
    cell_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      beats_out++;
      if (pending_cells.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h", $time, m_tdata);
        errors++;
      end else begin
        e = pending_cells.pop_front();
        if (m_tdata[4:0] !== e.cx) begin
          $display("%0t: cell_x expected %0d actual %0d", $time, e.cx, m_tdata[4:0]);
          errors++;
        end
        if (m_tdata[9:5] !== e.cz) begin
          $display("%0t: cell_z expected %0d actual %0d", $time, e.cz, m_tdata[9:5]);
          errors++;
        end
        if (m_tdata[10] !== e.chg) begin
          $display("%0t: cell_changed expected %0d actual %0d", $time, e.chg, m_tdata[10]);
          errors++;
        end
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_directed;
    set_world(-24'sd32768, -24'sd16384, 24'sd32768, 24'h7FFFFF, 24'd2048, 6'd32, 6'd20);
    send_item(OP_PLACE, 24'h800000, 24'h800000, 5'd0, 5'd0);
    send_item(OP_PLACE, 24'h7FFFFF, 24'h7FFFFF, 5'd0, 5'd0);
    send_item(OP_PLACE, 24'h000000, 24'h000000, 5'd31, 5'd31);
    send_item(OP_PLACE, -24'sd32768, -24'sd16384, 5'd0, 5'd0);
    send_item(OP_PLACE, 24'sd2047, 24'sd2048, 5'd0, 5'd0);
    send_item(OP_MOVE, 24'h000000, 24'h000000, 5'd16, 5'd8);
    send_item(OP_MOVE, 24'h000000, 24'h000000, 5'd16, 5'd9);
    send_item(OP_MOVE, 24'h7FFFFF, 24'h800000, 5'd16, 5'd8);
    send_item(OP_REMOVE, 24'h7FFFFF, 24'h7FFFFF, 5'd31, 5'd19);
    send_item(OP_REMOVE, 24'h000000, 24'h000000, 5'd31, 5'd31);
    send_item(OP_REMOVE, 24'h000000, 24'h000000, 5'd0, 5'd0);
    send_item(OP_REMOVE, 24'h000000, 24'h000000, 5'd0, 5'd0);
    send_item(OP_REMOVE, 24'h000000, 24'h000000, 5'd0, 5'd0);
    send_item(OP_NOP, 24'h123456, 24'h654321, 5'd21, 5'd10);
    send_item(OP_NOP, 24'hFFFFFF, 24'hFFFFFF, 5'd31, 5'd31);
  endtask

  task automatic test_odd_config;
    // zero cell size, zero cols, oversized rows
    set_world(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'd0, 6'd0, 6'd63);
    send_item(OP_PLACE, 24'h7FFFFF, 24'h7FFFFF, 5'd0, 5'd0);
    send_item(OP_PLACE, 24'h800000, 24'h800010, 5'd0, 5'd0);
    send_item(OP_MOVE, 24'h000000, 24'h000000, 5'd0, 5'd31);
    repeat (40) random_item();
    // inverted rectangle
    set_world(24'sd4096, 24'sd4096, -24'sd4096, -24'sd4096, 24'd256, 6'd8, 6'd8);
    send_item(OP_PLACE, 24'sd5000, 24'sd5000, 5'd0, 5'd0);
    send_item(OP_MOVE, 24'h7FFFFF, 24'h800000, 5'd3, 5'd3);
    repeat (40) random_item();
    // largest cell size, tiny grid
    set_world(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 6'd1, 6'd2);
    send_item(OP_PLACE, 24'h7FFFFF, 24'h7FFFFF, 5'd0, 5'd0);
    send_item(OP_REMOVE, 24'h0, 24'h0, 5'd1, 5'd1);
    repeat (40) random_item();
  endtask

  task automatic test_random;
    for (int ph = 0; ph < 6; ph++) begin
      set_world(-24'($urandom_range(65536)), -24'($urandom_range(65536)),
                24'($urandom_range(65536)), 24'($urandom_range(65536)),
                24'($urandom_range(8192, 64)), 6'($urandom_range(32, 1)),
                6'($urandom_range(32, 1)));
      calm = (ph == 2);
      repeat (140) random_item();
      calm = 0;
    end
  endtask

  task automatic test_backpressure;
    set_world(-24'sd8192, -24'sd8192, 24'sd8192, 24'sd8192, 24'd512, 6'd32, 6'd32);
    calm = 1;
    @(posedge clk);
    hold_cycles <= 400;
    repeat (20) random_item();
    calm = 0;
    repeat (20) random_item();
  endtask

  initial begin
    g_min_x = 0; g_min_z = 0; g_max_x = 0; g_max_z = 0;
    g_cell = 23'd256; g_cols = 6'd32; g_rows = 6'd32;
    foreach (occ[i]) occ[i] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_odd_config();
    test_backpressure();
    test_random();
    settle();
    $display("covered %0d beats in, %0d beats out, %0d cell-changing moves, %0d world setups",
             beats_in, beats_out, moves_changed, cfg_phases);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/gcno_pkg.sv
rtl/gcno_ram.sv
rtl/gcno_front.sv
rtl/gcno_queue.sv
rtl/gcno_back.sv
rtl/grid_cell_neighbourhood_occupancy.sv
test/tb_grid_cell_neighbourhood_occupancy.sv
